/* src/akd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package akd_pkg;

    typedef enum logic [2:0] {
        ST_ASCII   = 3'd0,
        ST_ESC     = 3'd1,
        ST_CSI     = 3'd2,
        ST_PARAM   = 3'd3,
        ST_FN_O    = 3'd4,
        ST_FN_BR   = 3'd5,
        ST_CHARSET = 3'd6
    } state_t;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_KEY     = 2'd1,
        KIND_ERR     = 2'd2,
        KIND_CHANGED = 2'd3
    } kind_t;

    localparam logic [7:0] KEY_DEL   = 8'd0;
    localparam logic [7:0] KEY_BKSP  = 8'd1;
    localparam logic [7:0] KEY_TAB   = 8'd2;
    localparam logic [7:0] KEY_LF    = 8'd3;
    localparam logic [7:0] KEY_CR    = 8'd4;
    localparam logic [7:0] KEY_BREAK = 8'd5;
    localparam logic [7:0] KEY_UP    = 8'd6;
    localparam logic [7:0] KEY_DOWN  = 8'd7;
    localparam logic [7:0] KEY_RIGHT = 8'd8;
    localparam logic [7:0] KEY_LEFT  = 8'd9;
    localparam logic [7:0] KEY_HOME  = 8'd10;
    localparam logic [7:0] KEY_INS   = 8'd11;
    localparam logic [7:0] KEY_END   = 8'd12;
    localparam logic [7:0] KEY_PGUP  = 8'd13;
    localparam logic [7:0] KEY_PGDN  = 8'd14;
    localparam logic [7:0] KEY_F1    = 8'd15;
    localparam logic [7:0] KEY_LAST  = 8'd26;

    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [7:0] FN_O_BASE  = 8'd80;
    localparam logic [7:0] FN_BR_BASE = 8'h41;
    localparam logic [7:0] FN_SPAN    = 8'd11;
    localparam logic [7:0] TILDE_MAX  = 8'd24;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } decode_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } tilde_t;

    function automatic tilde_t tilde_key(input logic [7:0] p);
        tilde_t t;
        t.hit  = 1'b1;
        t.code = KEY_HOME;
        unique case (p)
            8'd1:  t.code = KEY_HOME;
            8'd2:  t.code = KEY_INS;
            8'd4:  t.code = KEY_END;
            8'd5:  t.code = KEY_PGUP;
            8'd6:  t.code = KEY_PGDN;
            8'd15: t.code = KEY_F1 + 8'd4;
            8'd17: t.code = KEY_F1 + 8'd5;
            8'd18: t.code = KEY_F1 + 8'd6;
            8'd19: t.code = KEY_F1 + 8'd7;
            8'd20: t.code = KEY_F1 + 8'd8;
            8'd21: t.code = KEY_F1 + 8'd9;
            8'd23: t.code = KEY_F1 + 8'd10;
            8'd24: t.code = KEY_F1 + 8'd11;
            default: t.hit = 1'b0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* src/akd_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module akd_parser (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire [7:0]       rx_byte,
    input  wire             end_of_chunk,
    input  wire             take,
    output akd_pkg::decode_t dec
);

    akd_pkg::state_t state_reg, state_next;
    logic [7:0]      param_reg, param_next;
    logic            closed_reg, closed_next;

    logic            have;
    akd_pkg::kind_t  kind;
    logic [7:0]      code;
    logic            is_digit;
    logic [11:0]     acc;
    logic [7:0]      fn_base;
    logic [7:0]      fn_off;
    akd_pkg::tilde_t tk;
    akd_pkg::result_t r_key;
    akd_pkg::result_t r_chg;

    assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    assign acc      = 12'(param_reg) * 12'd10 + 12'(rx_byte[3:0]);
    assign fn_base  = (state_reg == akd_pkg::ST_FN_O) ? akd_pkg::FN_O_BASE
                                                       : akd_pkg::FN_BR_BASE;
    assign fn_off   = rx_byte - fn_base;
    assign tk       = akd_pkg::tilde_key(param_reg);

    always_comb begin
        have        = 1'b0;
        kind        = akd_pkg::KIND_ERR;
        code        = rx_byte;
        state_next  = state_reg;
        param_next  = param_reg;
        closed_next = closed_reg;
        unique case (state_reg)
            akd_pkg::ST_ASCII: begin
                if (rx_byte < akd_pkg::CH_SPACE || rx_byte == akd_pkg::CH_DEL) begin
                    kind = akd_pkg::KIND_KEY;
                    unique case (rx_byte)
                        akd_pkg::CH_ESC: state_next = akd_pkg::ST_ESC;
                        akd_pkg::CH_DEL: begin have = 1'b1; code = akd_pkg::KEY_DEL; end
                        akd_pkg::CH_BS:  begin have = 1'b1; code = akd_pkg::KEY_BKSP; end
                        akd_pkg::CH_TAB: begin have = 1'b1; code = akd_pkg::KEY_TAB; end
                        akd_pkg::CH_LF:  begin have = 1'b1; code = akd_pkg::KEY_LF; end
                        akd_pkg::CH_CR:  begin have = 1'b1; code = akd_pkg::KEY_CR; end
                        default: ;
                    endcase
                end else begin
                    have = 1'b1;
                    kind = akd_pkg::KIND_CHAR;
                end
            end
            akd_pkg::ST_ESC: begin
                if (rx_byte == 8'h5B) begin
                    state_next = akd_pkg::ST_CSI;
                end else if (rx_byte == 8'h28 || rx_byte == 8'h29) begin
                    state_next = akd_pkg::ST_CHARSET;
                end else if (rx_byte == 8'h4F) begin
                    state_next = akd_pkg::ST_FN_O;
                end else begin
                    have       = 1'b1;
                    state_next = akd_pkg::ST_ASCII;
                end
            end
            akd_pkg::ST_CSI: begin
                state_next = akd_pkg::ST_ASCII;
                if (rx_byte == 8'h3F) begin
                    param_next  = 8'd0;
                    closed_next = 1'b0;
                    state_next  = akd_pkg::ST_PARAM;
                end else if (rx_byte == 8'h5B) begin
                    state_next = akd_pkg::ST_FN_BR;
                end else if (is_digit) begin
                    param_next  = {4'd0, rx_byte[3:0]};
                    closed_next = 1'b0;
                    state_next  = akd_pkg::ST_PARAM;
                end else begin
                    have = 1'b1;
                    kind = akd_pkg::KIND_KEY;
                    unique case (rx_byte)
                        8'h50: code = akd_pkg::KEY_BREAK;
                        8'h41: code = akd_pkg::KEY_UP;
                        8'h42: code = akd_pkg::KEY_DOWN;
                        8'h43: code = akd_pkg::KEY_RIGHT;
                        8'h44: code = akd_pkg::KEY_LEFT;
                        default: kind = akd_pkg::KIND_ERR;
                    endcase
                end
            end
            akd_pkg::ST_PARAM: begin
                if (is_digit) begin
                    if (!closed_reg) begin
                        param_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
                    end
                end else if (rx_byte == 8'h3B) begin
                    closed_next = 1'b1;
                end else begin
                    if (rx_byte == 8'h7E && param_reg <= akd_pkg::TILDE_MAX && tk.hit) begin
                        have = 1'b1;
                        kind = akd_pkg::KIND_KEY;
                        code = tk.code;
                    end
                    param_next  = 8'd0;
                    closed_next = 1'b0;
                    state_next  = akd_pkg::ST_ASCII;
                end
            end
            akd_pkg::ST_FN_O, akd_pkg::ST_FN_BR: begin
                have       = 1'b1;
                state_next = akd_pkg::ST_ASCII;
                if (rx_byte >= fn_base && fn_off <= akd_pkg::FN_SPAN) begin
                    kind = akd_pkg::KIND_KEY;
                    code = akd_pkg::KEY_F1 + fn_off;
                end
            end
            default: begin
                have       = 1'b1;
                state_next = akd_pkg::ST_ASCII;
            end
        endcase
    end

    always_comb begin
        r_key.kind = kind;
        r_key.code = code;
        r_key.last = !end_of_chunk;
        r_chg.kind = akd_pkg::KIND_CHANGED;
        r_chg.code = 8'd0;
        r_chg.last = 1'b1;
        dec.count  = {1'b0, have} + {1'b0, end_of_chunk};
        dec.res0   = have ? r_key : r_chg;
        dec.res1   = r_chg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= akd_pkg::ST_ASCII;
            param_reg  <= 8'd0;
            closed_reg <= 1'b0;
        end else if (take) begin
            state_reg  <= state_next;
            param_reg  <= param_next;
            closed_reg <= closed_next;
        end
    end

endmodule

`default_nettype wire

/* src/akd_result_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module akd_result_queue (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  akd_pkg::decode_t dec,
    output logic             room,
    output logic             m_valid,
    output akd_pkg::result_t m_word,
    input  wire              m_ready
);

    akd_pkg::result_t entry_reg [2];
    logic             rd_ptr_reg;
    logic             wr_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;
    logic [1:0]       free;
    logic [1:0]       n_push;

    assign m_valid = (count_reg != 2'd0);
    assign m_word  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign free    = 2'd2 - count_reg + {1'b0, pop};
    assign room    = (dec.count <= free);
    assign n_push  = push ? dec.count : 2'd0;
    assign count_next = count_reg - {1'b0, pop} + n_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_reg ^ pop;
            wr_ptr_reg <= wr_ptr_reg ^ n_push[0];
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            entry_reg[wr_ptr_reg] <= dec.res0;
        end
        if (n_push == 2'd2) begin
            entry_reg[!wr_ptr_reg] <= dec.res1;
        end
    end

endmodule

`default_nettype wire

/* src/ansi_key_escape_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Terminal key decoder: takes one received byte per word on the s_ side and
// emits key events on the m_ side. Plain bytes become character events,
// DEL/BS/TAB/LF/CR and ANSI escape sequences (arrows, break, F1..F12, home,
// insert, end, page up/down) become special-key events, malformed sequences
// give an error event carrying the offending byte (a bad parameter sequence
// gives none), and a byte marked with s_tlast is followed by a
// terminal-changed event; m_tlast marks the last event of each input byte.
// An input byte is registered when taken and decoded through one level of
// logic between the input register and a two-entry result queue, so the block
// sustains one byte per cycle while each byte yields at most one event and
// the output is not stalled; a byte that yields two events (one ending a
// chunk) gives two output words.
module ansi_key_escape_decoder_top (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire        s_tlast,   // end_of_chunk
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata,  // [1:0] event_kind, [9:2] key_code, [15:10] zero
    output logic       m_tlast    // last
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eoc_reg;
    logic             take;
    logic             room;
    akd_pkg::decode_t dec;
    akd_pkg::result_t out_word;

    assign take     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eoc_reg  <= s_tlast;
        end
    end

    akd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rx_byte      (in_byte_reg),
        .end_of_chunk (in_eoc_reg),
        .take         (take),
        .dec          (dec)
    );

    akd_result_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (take),
        .dec     (dec),
        .room    (room),
        .m_valid (m_tvalid),
        .m_word  (out_word),
        .m_ready (m_tready)
    );

    assign m_tdata = {6'd0, out_word.code, out_word.kind};
    assign m_tlast = out_word.last;

endmodule

`default_nettype wire

/* src/akd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module akd_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [7:0]  s_tdata,
    input wire        s_tlast,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire        m_tlast
);

    logic       unused_in;
    logic [1:0] kind;
    logic [7:0] code;

    assign unused_in = s_tvalid ^ s_tready ^ s_tlast ^ (^s_tdata);
    assign kind      = m_tdata[1:0];
    assign code      = m_tdata[9:2];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    a_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind == akd_pkg::KIND_CHANGED |-> m_tlast && code == 8'd0)
        else $error("changed event malformed");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind == akd_pkg::KIND_KEY |-> code <= akd_pkg::KEY_LAST)
        else $error("special key out of range");

    a_char_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind == akd_pkg::KIND_CHAR
            |-> code >= akd_pkg::CH_SPACE && code != akd_pkg::CH_DEL)
        else $error("control byte emitted as character");

endmodule

bind ansi_key_escape_decoder_top akd_checker u_akd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/tb_ansi_key_escape_decoder_top.sv */
`timescale 1ns / 1ps

module tb_ansi_key_escape_decoder_top;
    import akd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 1850;

    typedef struct packed {
        logic [7:0] rx;
        logic       eoc;
        logic       typed;
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    localparam result_t NO_EVT = '{KIND_CHAR, 8'd0, 1'b0};

    localparam int N_DIRECTED = 26;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{8'h00,  1'b0, 1'b1, 2'd0, NO_EVT, NO_EVT},
        '{8'hFF,  1'b1, 1'b1, 2'd2, '{KIND_CHAR, 8'hFF, 1'b0}, '{KIND_CHANGED, 8'd0, 1'b1}},
        '{CH_DEL, 1'b0, 1'b1, 2'd1, '{KIND_KEY, KEY_DEL, 1'b1}, NO_EVT},
        '{CH_BS,  1'b0, 1'b1, 2'd1, '{KIND_KEY, KEY_BKSP, 1'b1}, NO_EVT},
        '{CH_ESC, 1'b0, 1'b1, 2'd0, NO_EVT, NO_EVT},
        '{"Z",    1'b0, 1'b1, 2'd1, '{KIND_ERR, "Z", 1'b1}, NO_EVT},
        '{CH_ESC, 1'b0, 1'b1, 2'd0, NO_EVT, NO_EVT},
        '{"O",    1'b0, 1'b1, 2'd0, NO_EVT, NO_EVT},
        '{8'h5C,  1'b0, 1'b1, 2'd1, '{KIND_ERR, 8'h5C, 1'b1}, NO_EVT},
        '{CH_ESC, 1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"[",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"[",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"L",    1'b1, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{CH_ESC, 1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"[",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"2",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"4",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{";",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"9",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"~",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{CH_ESC, 1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"[",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{"A",    1'b0, 1'b0, 2'd0, NO_EVT, NO_EVT},
        '{CH_ESC, 1'b0, 1'b1, 2'd0, NO_EVT, NO_EVT},
        '{"(",    1'b0, 1'b1, 2'd0, NO_EVT, NO_EVT},
        '{"B",    1'b0, 1'b1, 2'd1, '{KIND_ERR, "B", 1'b1}, NO_EVT}
    };

    localparam int TILDE_HITS [13] = '{1, 2, 4, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    ansi_key_escape_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    result_t    expected_events [$];
    logic [7:0] pending_bytes [$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    int         rx_hold = 0;

    state_t     parse_st = ST_ASCII;
    logic [7:0] param_val = 8'd0;
    logic       param_done = 1'b0;

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // advance the decoder image by one byte and, when keep is set, queue the events it yields
    task automatic predict_events(input logic [7:0] b, input logic eoc, input bit keep);
        bit         have;
        kind_t      k;
        logic [7:0] c;
        logic [7:0] base;
        int         acc;
        have = 1'b0;
        k    = KIND_CHAR;
        c    = 8'd0;
        case (parse_st)
            ST_ASCII: begin
                if (b < CH_SPACE || b == CH_DEL) begin
                    case (b)
                        CH_ESC: parse_st = ST_ESC;
                        CH_DEL: begin have = 1'b1; k = KIND_KEY; c = KEY_DEL; end
                        CH_BS:  begin have = 1'b1; k = KIND_KEY; c = KEY_BKSP; end
                        CH_TAB: begin have = 1'b1; k = KIND_KEY; c = KEY_TAB; end
                        CH_LF:  begin have = 1'b1; k = KIND_KEY; c = KEY_LF; end
                        CH_CR:  begin have = 1'b1; k = KIND_KEY; c = KEY_CR; end
                        default: ;
                    endcase
                end else begin
                    have = 1'b1; k = KIND_CHAR; c = b;
                end
            end
            ST_ESC: begin
                if (b == "[") parse_st = ST_CSI;
                else if (b == "(" || b == ")") parse_st = ST_CHARSET;
                else if (b == "O") parse_st = ST_FN_O;
                else begin
                    have = 1'b1; k = KIND_ERR; c = b; parse_st = ST_ASCII;
                end
            end
            ST_CSI: begin
                parse_st = ST_ASCII;
                if (b == "?") begin
                    param_val = 8'd0; param_done = 1'b0; parse_st = ST_PARAM;
                end else if (b == "[") begin
                    parse_st = ST_FN_BR;
                end else if (b >= "0" && b <= "9") begin
                    param_val = b - "0"; param_done = 1'b0; parse_st = ST_PARAM;
                end else begin
                    have = 1'b1;
                    k    = KIND_KEY;
                    case (b)
                        "P": c = KEY_BREAK;
                        "A": c = KEY_UP;
                        "B": c = KEY_DOWN;
                        "C": c = KEY_RIGHT;
                        "D": c = KEY_LEFT;
                        default: begin k = KIND_ERR; c = b; end
                    endcase
                end
            end
            ST_PARAM: begin
                if (b >= "0" && b <= "9") begin
                    if (!param_done) begin
                        acc = int'(param_val) * 10 + int'(b - "0");
                        param_val = (acc > 255) ? 8'd255 : acc[7:0];
                    end
                end else if (b == ";") begin
                    param_done = 1'b1;
                end else begin
                    if (b == "~" && param_val <= TILDE_MAX) begin
                        have = 1'b1;
                        k    = KIND_KEY;
                        case (param_val)
                            8'd1:  c = KEY_HOME;
                            8'd2:  c = KEY_INS;
                            8'd4:  c = KEY_END;
                            8'd5:  c = KEY_PGUP;
                            8'd6:  c = KEY_PGDN;
                            8'd15: c = KEY_F1 + 8'd4;
                            8'd17: c = KEY_F1 + 8'd5;
                            8'd18: c = KEY_F1 + 8'd6;
                            8'd19: c = KEY_F1 + 8'd7;
                            8'd20: c = KEY_F1 + 8'd8;
                            8'd21: c = KEY_F1 + 8'd9;
                            8'd23: c = KEY_F1 + 8'd10;
                            8'd24: c = KEY_F1 + 8'd11;
                            default: have = 1'b0;
                        endcase
                    end
                    param_val  = 8'd0;
                    param_done = 1'b0;
                    parse_st   = ST_ASCII;
                end
            end
            ST_FN_O, ST_FN_BR: begin
                base = (parse_st == ST_FN_O) ? FN_O_BASE : FN_BR_BASE;
                have = 1'b1;
                if (b >= base && (b - base) <= FN_SPAN) begin
                    k = KIND_KEY; c = KEY_F1 + (b - base);
                end else begin
                    k = KIND_ERR; c = b;
                end
                parse_st = ST_ASCII;
            end
            default: begin
                have = 1'b1; k = KIND_ERR; c = b; parse_st = ST_ASCII;
            end
        endcase
        if (keep) begin
            if (have)
                expected_events.push_back('{k, c, ~eoc});
            if (eoc)
                expected_events.push_back('{KIND_CHANGED, 8'd0, 1'b1});
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eoc, input bit keep);
        int gap;
        gap = tx_calm ? 0 : (($urandom_range(0, 99) < 40) ? idle_len() : 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoc;
        do @(posedge aclk); while (!s_tready);
        predict_events(b, eoc, keep);
    endtask

    // hold off the sender until every queued event has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
    endtask

    task automatic push_number(input int v);
        string digits;
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
            pending_bytes.push_back(digits[i]);
    endtask

    task automatic build_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 30) begin
            case ($urandom_range(0, 5))
                0: pending_bytes.push_back(CH_DEL);
                1: pending_bytes.push_back(CH_BS);
                2: pending_bytes.push_back(CH_TAB);
                3: pending_bytes.push_back(CH_LF);
                4: pending_bytes.push_back(CH_CR);
                default: pending_bytes.push_back(8'($urandom_range(32, 126)));
            endcase
        end else begin
            pending_bytes.push_back(CH_ESC);
            if (pick < 45) begin
                pending_bytes.push_back("[");
                case ($urandom_range(0, 4))
                    0: pending_bytes.push_back("A");
                    1: pending_bytes.push_back("B");
                    2: pending_bytes.push_back("C");
                    3: pending_bytes.push_back("D");
                    default: pending_bytes.push_back("P");
                endcase
            end else if (pick < 55) begin
                pending_bytes.push_back("O");
                pending_bytes.push_back(8'(($urandom_range(0, 9) == 0) ?
                                        $urandom_range(0, 255) : $urandom_range(76, 95)));
            end else if (pick < 63) begin
                pending_bytes.push_back("[");
                pending_bytes.push_back("[");
                pending_bytes.push_back(8'(($urandom_range(0, 9) == 0) ?
                                        $urandom_range(0, 255) : $urandom_range(61, 80)));
            end else if (pick < 83) begin
                pending_bytes.push_back("[");
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: push_number(TILDE_HITS[$urandom_range(0, 12)]);
                    5, 6, 7:       push_number($urandom_range(0, 30));
                    8:             push_number($urandom_range(0, 999));
                    default:       push_number($urandom_range(0, 99999));
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    pending_bytes.push_back(";");
                    push_number($urandom_range(0, 99));
                end
                pending_bytes.push_back(($urandom_range(0, 99) < 85) ?
                                        8'("~") : 8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                pending_bytes.push_back("[");
                pending_bytes.push_back("?");
                push_number($urandom_range(0, 99));
                pending_bytes.push_back("c");
            end else if (pick < 93) begin
                pending_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'("(") : 8'(")"));
                pending_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 97) begin
                pending_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                pending_bytes.push_back("[");
                pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0)
            rx_calm = !rx_calm;
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            rx_hold = idle_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind_t'(m_tdata[1:0]), m_tdata[9:2], m_tlast};
            if (expected_events.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word kind %0d code %0d last %0d",
                         $time, got.kind, got.code, got.last);
            end else begin
                want = expected_events.pop_front();
                if (got !== want || m_tdata[15:10] !== 6'd0) begin
                    mismatches++;
                    $display("%0t: expected kind %0d code %0d last %0d, got kind %0d code %0d last %0d pad %h",
                             $time, want.kind, want.code, want.last,
                             got.kind, got.code, got.last, m_tdata[15:10]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[ansi_key_escape_decoder_top] ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        int        sent;
        bit        paused;
        sent   = 0;
        paused = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            send_byte(row.rx, row.eoc, !row.typed);
            if (row.typed && row.cnt > 0)
                expected_events.push_back(row.r0);
            if (row.typed && row.cnt > 1)
                expected_events.push_back(row.r1);
        end
        drain();

        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 3)
                tx_calm = !tx_calm;
            build_sequence();
            while (pending_bytes.size() != 0) begin
                send_byte(pending_bytes.pop_front(), $urandom_range(0, 9) == 0, 1'b1);
                sent++;
            end
            if (!paused && sent >= RANDOM_BYTES / 2) begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("[ansi_key_escape_decoder_top] OK");
        else
            $display("[ansi_key_escape_decoder_top] ERROR");
        $finish;
    end

endmodule
